/* sv/tsmd_pkg.sv */
// ----------------------------------------------------------------------------
// Track-straw max drift: shared package
// Constants, reset defaults, field widths and types used across the block.
// ----------------------------------------------------------------------------
package tsmd_pkg;

    // Fractional bits of all lengths (mm scaled by 2^COORD_FRAC_BITS).
    localparam int unsigned COORD_FRAC_BITS = 16;

    // Register widths.
    localparam int unsigned SEP_W    = 31;
    localparam int unsigned PITCH_W  = 16;
    localparam int unsigned RADIUS_W = 24;
    localparam int unsigned CFG_W    = 31;

    // Reset defaults: 10 mm, 0.05 mm rounded to nearest, 2.5 mm; saturating.
    localparam longint unsigned SEP_RAW    = 64'd10 << COORD_FRAC_BITS;
    localparam longint unsigned PITCH_RAW  = ((64'd5 << COORD_FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned RADIUS_RAW = 64'd5 << (COORD_FRAC_BITS - 1);
    localparam logic [SEP_W-1:0] DEF_SEP =
        (SEP_RAW > 64'h7FFF_FFFF) ? {SEP_W{1'b1}} : SEP_W'(SEP_RAW);
    localparam logic [PITCH_W-1:0] DEF_PITCH =
        (PITCH_RAW > 64'hFFFF) ? {PITCH_W{1'b1}} : PITCH_W'(PITCH_RAW);
    localparam logic [RADIUS_W-1:0] DEF_RADIUS =
        (RADIUS_RAW > 64'hFF_FFFF) ? {RADIUS_W{1'b1}} : RADIUS_W'(RADIUS_RAW);

    // Stream widths.
    localparam int unsigned IN_DATA_W  = 168;
    localparam int unsigned OUT_DATA_W = 64;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_PLANE_SEP = 2'd0,
        REG_PIXEL_PITCH = 2'd1,
        REG_STRAW_RADIUS = 2'd2
    } cfg_index_t;

    // Geometry settings seen by the front end.
    typedef struct packed {
        logic [SEP_W-1:0]   sep;
        logic [PITCH_W-1:0] pitch;
    } geom_cfg_t;

    // Magnitudes of the three cross products and their quotients.
    typedef logic [65:0] num_t;
    typedef logic [32:0] quot_t;

    // Sideband carried alongside a square-root pipeline.
    localparam int unsigned SIDE_W = 198;
    typedef logic [SIDE_W-1:0] side_t;

endpackage

/* sv/tsmd_front.sv */
// ----------------------------------------------------------------------------
// Track-straw max drift: front end
// Converts plane crossings to lengths and forms the three cross products and
// the squared track length over five register stages.
// ----------------------------------------------------------------------------
module tsmd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ce,
    input  tsmd_pkg::geom_cfg_t               cfg,
    input  logic                              in_valid,
    input  logic [tsmd_pkg::IN_DATA_W-1:0]    in_data,
    output logic                              out_valid,
    output logic [62:0]                       out_lensq,
    output tsmd_pkg::num_t                    out_num [3]
);

    // Stage A registers.
    logic               a_valid_reg;
    logic [27:0]        a_xt_reg, a_xb_reg;
    logic [30:0]        a_s_reg;
    logic signed [31:0] a_px_reg, a_py_reg, a_cx_reg, a_cy_reg;

    // Stage B registers.
    logic               b_valid_reg;
    logic signed [28:0] b_dx_reg;
    logic signed [33:0] b_dcx_reg, b_dpx_reg;
    logic signed [32:0] b_dpcx_reg, b_dpcy_reg;
    logic signed [31:0] b_cy_reg, b_py_reg;
    logic [30:0]        b_s_reg;

    // Stage C registers.
    logic               c_valid_reg;
    logic signed [65:0] c_m1_reg, c_m5_reg;
    logic signed [60:0] c_m2_reg, c_m6_reg;
    logic signed [61:0] c_m3_reg;
    logic signed [64:0] c_m4_reg;
    logic [55:0]        c_dx2_reg;
    logic [61:0]        c_s2_reg;

    // Stage D registers.
    logic               d_valid_reg;
    logic signed [66:0] d_n_reg [3];
    logic [62:0]        d_lensq_reg;

    // Stage E registers.
    logic               e_valid_reg;
    tsmd_pkg::num_t     e_num_reg [3];
    logic [62:0]        e_lensq_reg;

    logic [35:0]        xt_prod, xb_prod;
    logic signed [57:0] dx_sq;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Pixel positions scaled by the pitch, rounded half up.
    assign xt_prod = 36'(in_data[19:0]) * 36'(cfg.pitch) + 36'd128;
    assign xb_prod = 36'(in_data[39:20]) * 36'(cfg.pitch) + 36'd128;
    assign dx_sq   = 58'(b_dx_reg) * 58'(b_dx_reg);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // Stage A: track positions on both planes.
            a_xt_reg <= xt_prod[35:8];
            a_xb_reg <= xb_prod[35:8];
            a_s_reg  <= (cfg.sep == '0) ? 31'd1 : cfg.sep;
            a_px_reg <= $signed(in_data[71:40]);
            a_py_reg <= $signed(in_data[103:72]);
            a_cx_reg <= $signed(in_data[135:104]);
            a_cy_reg <= $signed(in_data[167:136]);

            // Stage B: differences.
            b_dx_reg   <= $signed({1'b0, a_xt_reg}) - $signed({1'b0, a_xb_reg});
            b_dcx_reg  <= $signed({{2{a_cx_reg[31]}}, a_cx_reg}) - $signed({6'd0, a_xb_reg});
            b_dpx_reg  <= $signed({{2{a_px_reg[31]}}, a_px_reg}) - $signed({6'd0, a_xb_reg});
            b_dpcx_reg <= $signed({a_px_reg[31], a_px_reg}) - $signed({a_cx_reg[31], a_cx_reg});
            b_dpcy_reg <= $signed({a_py_reg[31], a_py_reg}) - $signed({a_cy_reg[31], a_cy_reg});
            b_cy_reg   <= a_cy_reg;
            b_py_reg   <= a_py_reg;
            b_s_reg    <= a_s_reg;

            // Stage C: products.
            c_m1_reg  <= 66'(b_dcx_reg) * 66'($signed({1'b0, b_s_reg}));
            c_m2_reg  <= 61'(b_cy_reg) * 61'(b_dx_reg);
            c_m3_reg  <= 62'(b_dpcx_reg) * 62'(b_dx_reg);
            c_m4_reg  <= 65'(b_dpcy_reg) * 65'($signed({1'b0, b_s_reg}));
            c_m5_reg  <= 66'(b_dpx_reg) * 66'($signed({1'b0, b_s_reg}));
            c_m6_reg  <= 61'(b_py_reg) * 61'(b_dx_reg);
            c_dx2_reg <= dx_sq[55:0];
            c_s2_reg  <= 62'(b_s_reg) * 62'(b_s_reg);

            // Stage D: cross products and squared length.
            d_n_reg[0]  <= 67'(c_m1_reg) - 67'(c_m2_reg);
            d_n_reg[1]  <= 67'(c_m3_reg) + 67'(c_m4_reg);
            d_n_reg[2]  <= 67'(c_m5_reg) - 67'(c_m6_reg);
            d_lensq_reg <= 63'(c_dx2_reg) + 63'(c_s2_reg);

            // Stage E: magnitudes.
            for (int i = 0; i < 3; i++)
            begin
                e_num_reg[i] <= d_n_reg[i][66] ? 66'(-d_n_reg[i]) : d_n_reg[i][65:0];
            end
            e_lensq_reg <= d_lensq_reg;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_lensq = e_lensq_reg;
    assign out_num   = e_num_reg;

endmodule

/* sv/tsmd_sqrt.sv */
// ----------------------------------------------------------------------------
// Track-straw max drift: pipelined integer square root
// Floor square root of a 64-bit value, one root bit per stage over 32 stages,
// with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module tsmd_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [63:0]         in_rad,
    input  tsmd_pkg::side_t     in_side,
    output logic                out_valid,
    output logic [31:0]         out_root,
    output tsmd_pkg::side_t     out_side
);

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } sq_acc_t;

    // One restoring step: bring in two radicand bits, try a one root bit.
    function automatic sq_acc_t sq_step(sq_acc_t acc, logic [1:0] pair);
        logic [35:0] shifted;
        logic [35:0] trial;
        sq_acc_t     res;
        shifted = {acc.rem, pair};
        trial   = {2'b00, acc.root, 2'b01};
        if (shifted >= trial)
        begin
            res.rem  = 34'(shifted - trial);
            res.root = {acc.root[30:0], 1'b1};
        end
        else
        begin
            res.rem  = shifted[33:0];
            res.root = {acc.root[30:0], 1'b0};
        end
        return res;
    endfunction

    logic            valid_reg [32];
    sq_acc_t         acc_reg   [32];
    logic [63:0]     rad_reg   [32];
    tsmd_pkg::side_t side_reg  [32];

    // Stage zero starts from the input.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            acc_reg[0]  <= sq_step('0, in_rad[63:62]);
            rad_reg[0]  <= {in_rad[61:0], 2'b00};
            side_reg[0] <= in_side;
        end
    end

    // Remaining root bits, one per stage.
    for (genvar k = 1; k < 32; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                acc_reg[k]  <= sq_step(acc_reg[k-1], rad_reg[k-1][63:62]);
                rad_reg[k]  <= {rad_reg[k-1][61:0], 2'b00};
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[31];
    assign out_root  = acc_reg[31].root;
    assign out_side  = side_reg[31];

endmodule

/* sv/tsmd_div.sv */
// ----------------------------------------------------------------------------
// Track-straw max drift: pipelined three-lane divider
// Divides three 66-bit magnitudes by one 32-bit length, one quotient bit per
// stage; quotients of 2^33 or more saturate to all ones.
// ----------------------------------------------------------------------------
module tsmd_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  tsmd_pkg::num_t      in_num [3],
    input  logic [31:0]         in_den,
    output logic                out_valid,
    output tsmd_pkg::quot_t     out_quot [3]
);

    logic        valid_reg [34];
    logic [31:0] den_reg   [34];
    logic        sat_reg   [34][3];
    logic [31:0] rem_reg   [34][3];
    logic [32:0] low_reg   [34][3];
    logic [32:0] quot_reg  [34][3];

    // Stage zero: overflow check and the upper part as the first remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            den_reg[0] <= in_den;
            for (int i = 0; i < 3; i++)
            begin
                sat_reg[0][i]  <= (in_num[i][65:33] >= {1'b0, in_den});
                rem_reg[0][i]  <= (in_num[i][65:33] >= {1'b0, in_den}) ? '0
                                  : in_num[i][64:33];
                low_reg[0][i]  <= in_num[i][32:0];
                quot_reg[0][i] <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 1; k < 34; k++)
    begin : g_stage
        logic [32:0] trial [3];
        logic        ge    [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {rem_reg[k-1][i], low_reg[k-1][i][32]};
                ge[i]    = (trial[i] >= {1'b0, den_reg[k-1]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                den_reg[k] <= den_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    sat_reg[k][i]  <= sat_reg[k-1][i];
                    rem_reg[k][i]  <= ge[i] ? 32'(trial[i] - {1'b0, den_reg[k-1]})
                                      : trial[i][31:0];
                    low_reg[k][i]  <= {low_reg[k-1][i][31:0], 1'b0};
                    quot_reg[k][i] <= {quot_reg[k-1][i][31:0], ge[i]};
                end
            end
        end
    end

    assign out_valid = valid_reg[33];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_quot[i] = sat_reg[33][i] ? '1 : quot_reg[33][i];
        end
    end

endmodule

/* sv/track_straw_max_drift_unit.sv */
// ----------------------------------------------------------------------------
// Track-straw max drift: top level
// Distance of closest approach of a straight track to a straw centre and the
// larger distance from a reference point to the track-circle intersections.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_ stream (plane crossings, point, straw centre) and
// leave on the m_ stream: tdata holds max_drift and closest_approach, tuser
// holds too_far. When too_far is set, max_drift is zero.
// The user must write the geometry registers through cfg_we/cfg_index/cfg_data
// only while no item is in flight; the block itself does not enforce this.
// Index 3 is ignored. Items pass from acceptance to m_tvalid through the front
// end, the three bit-serial square-root pipelines (32 stages each), the 34-stage
// divider, the multiplier stages around them and the output register.
// Throughput is one item per cycle. All stages share one enable: when the
// output register is full and m_tready is low, the whole pipeline holds and
// s_tready drops, so nothing is lost or repeated. Bubbles hold with the items.
// Reset clears every valid bit and loads the register defaults (10 mm plane
// separation, 0.05 mm pixel pitch, 2.5 mm straw radius).
// ----------------------------------------------------------------------------
module track_straw_max_drift_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [tsmd_pkg::CFG_W-1:0]          cfg_data,
    // Input stream. tdata: top_crossing, bottom_crossing, point_x, point_y,
    // centre_x, centre_y (lowest bits first).
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tsmd_pkg::IN_DATA_W-1:0]      s_tdata,
    // Output stream. tdata: max_drift, closest_approach. tuser: too_far.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tsmd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [0:0]                          m_tuser
);

    // Configuration registers.
    logic [tsmd_pkg::SEP_W-1:0]    sep_reg;
    logic [tsmd_pkg::PITCH_W-1:0]  pitch_reg;
    logic [tsmd_pkg::RADIUS_W-1:0] radius_reg;
    tsmd_pkg::geom_cfg_t           geom_cfg;

    logic ce;

    // Front end outputs.
    logic              fe_valid;
    logic [62:0]       fe_lensq;
    tsmd_pkg::num_t    fe_num [3];

    // Track length.
    logic              len_valid;
    logic [31:0]       len_root;
    tsmd_pkg::side_t   len_side;
    tsmd_pkg::num_t    len_num [3];

    // Quotients.
    logic              dv_valid;
    tsmd_pkg::quot_t   dv_quot [3];

    // Stage F.
    logic              f_valid_reg;
    logic [47:0]       f_r2_reg, f_d2_reg;
    logic [31:0]       f_doca_reg;
    logic              f_far_reg;
    logic [32:0]       f_par_reg, f_perp_reg;

    // Stage G.
    logic              g_valid_reg;
    logic [47:0]       g_rad_reg;
    logic              g_far_reg;
    logic [31:0]       g_doca_reg;
    logic [32:0]       g_par_reg, g_perp_reg;

    // Half chord.
    logic              hc_valid;
    logic [31:0]       hc_root;
    tsmd_pkg::side_t   hc_side;
    logic [33:0]       hc_sum;

    // Stages H, I, J.
    logic              h_valid_reg, i_valid_reg, j_valid_reg;
    logic [31:0]       h_a_reg, h_p_reg;
    logic              h_sat_reg, i_sat_reg, j_sat_reg;
    logic              h_far_reg, i_far_reg, j_far_reg;
    logic [31:0]       h_doca_reg, i_doca_reg, j_doca_reg;
    logic [63:0]       i_a2_reg, i_p2_reg;
    logic [63:0]       j_rad_reg;
    logic [64:0]       ij_sum;

    // Final hypotenuse.
    logic              hy_valid;
    logic [31:0]       hy_root;
    tsmd_pkg::side_t   hy_side;

    // Output register.
    logic              out_valid_reg;
    logic [31:0]       out_drift_reg, out_doca_reg;
    logic              out_far_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg    <= tsmd_pkg::DEF_SEP;
            pitch_reg  <= tsmd_pkg::DEF_PITCH;
            radius_reg <= tsmd_pkg::DEF_RADIUS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsmd_pkg::REG_PLANE_SEP:    sep_reg    <= cfg_data[tsmd_pkg::SEP_W-1:0];
                tsmd_pkg::REG_PIXEL_PITCH:  pitch_reg  <= cfg_data[tsmd_pkg::PITCH_W-1:0];
                tsmd_pkg::REG_STRAW_RADIUS: radius_reg <= cfg_data[tsmd_pkg::RADIUS_W-1:0];
                default:                    ;
            endcase
        end
    end

    assign geom_cfg.sep   = sep_reg;
    assign geom_cfg.pitch = pitch_reg;

    // One enable for the whole pipeline: hold while the output is stalled.
    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    tsmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .cfg       (geom_cfg),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (fe_valid),
        .out_lensq (fe_lensq),
        .out_num   (fe_num)
    );

    // Track length between the planes.
    tsmd_sqrt u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (fe_valid),
        .in_rad    ({1'b0, fe_lensq}),
        .in_side   ({fe_num[2], fe_num[1], fe_num[0]}),
        .out_valid (len_valid),
        .out_root  (len_root),
        .out_side  (len_side)
    );

    assign len_num[0] = len_side[65:0];
    assign len_num[1] = len_side[131:66];
    assign len_num[2] = len_side[197:132];

    // DOCA, along-track and perpendicular offsets.
    tsmd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (len_valid),
        .in_num    (len_num),
        .in_den    (len_root),
        .out_valid (dv_valid),
        .out_quot  (dv_quot)
    );

    // Valid bits of the back end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            j_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            f_valid_reg   <= dv_valid;
            g_valid_reg   <= f_valid_reg;
            h_valid_reg   <= hc_valid;
            i_valid_reg   <= h_valid_reg;
            j_valid_reg   <= i_valid_reg;
            out_valid_reg <= hy_valid;
        end
    end

    assign hc_sum = 34'(hc_side[98:66]) + 34'(hc_root);
    assign ij_sum = 65'(i_a2_reg) + 65'(i_p2_reg);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // Stage F: radius cut and squares for the half chord.
            f_r2_reg   <= 48'(radius_reg) * 48'(radius_reg);
            f_d2_reg   <= 48'(dv_quot[0][23:0]) * 48'(dv_quot[0][23:0]);
            f_doca_reg <= dv_quot[0][32] ? '1 : dv_quot[0][31:0];
            f_far_reg  <= (dv_quot[0] > 33'(radius_reg));
            f_par_reg  <= dv_quot[1];
            f_perp_reg <= dv_quot[2];

            // Stage G: squared half chord.
            g_rad_reg  <= f_far_reg ? '0 : 48'(f_r2_reg - f_d2_reg);
            g_far_reg  <= f_far_reg;
            g_doca_reg <= f_doca_reg;
            g_par_reg  <= f_par_reg;
            g_perp_reg <= f_perp_reg;

            // Stage H: far offset along the track and range check.
            h_a_reg    <= hc_sum[31:0];
            h_p_reg    <= hc_side[64:33] & 32'hFFFF_FFFF;
            h_sat_reg  <= (hc_sum[33:32] != 2'b00) || hc_side[65];
            h_far_reg  <= hc_side[0];
            h_doca_reg <= hc_side[32:1];

            // Stage I: squares.
            i_a2_reg   <= 64'(h_a_reg) * 64'(h_a_reg);
            i_p2_reg   <= 64'(h_p_reg) * 64'(h_p_reg);
            i_sat_reg  <= h_sat_reg;
            i_far_reg  <= h_far_reg;
            i_doca_reg <= h_doca_reg;

            // Stage J: sum of squares.
            j_rad_reg  <= ij_sum[63:0];
            j_sat_reg  <= i_sat_reg || ij_sum[64];
            j_far_reg  <= i_far_reg;
            j_doca_reg <= i_doca_reg;

            // Output register.
            out_doca_reg  <= hy_side[32:1];
            out_far_reg   <= hy_side[0];
            out_drift_reg <= hy_side[0] ? '0 : (hy_side[33] ? '1 : hy_root);
        end
    end

    // Half chord; sideband holds too_far, DOCA, perpendicular and parallel.
    tsmd_sqrt u_chord_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (g_valid_reg),
        .in_rad    (64'(g_rad_reg)),
        .in_side   (tsmd_pkg::side_t'({g_par_reg, g_perp_reg, g_doca_reg, g_far_reg})),
        .out_valid (hc_valid),
        .out_root  (hc_root),
        .out_side  (hc_side)
    );

    // Distance to the far intersection; sideband holds saturation, DOCA, too_far.
    tsmd_sqrt u_hyp_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (j_valid_reg),
        .in_rad    (j_rad_reg),
        .in_side   (tsmd_pkg::side_t'({j_sat_reg, j_doca_reg, j_far_reg})),
        .out_valid (hy_valid),
        .out_root  (hy_root),
        .out_side  (hy_side)
    );

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_doca_reg, out_drift_reg};
    assign m_tuser[0] = out_far_reg;

    // The flag agrees with the reported DOCA and the current radius.
    a_far_matches_doca: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tdata[63:32] > 32'(radius_reg))))
        else $error("too_far disagrees with closest_approach");

    // A track outside the straw reports no drift.
    a_far_zero_drift: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
        else $error("max_drift nonzero with too_far");

    // No item is taken in while the output is stalled.
    a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted during output stall");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Track-straw max drift: testbench
// This bench drives items on the input stream and checks every result against
// its own predictor of the block or a typed-in directed result. The predictor
// covers the distance of closest approach, the too-far cut and the larger
// point-to-intersection distance. A directed table comes first, then random
// items under several register settings, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One track-straw item.
    typedef struct {
        logic [19:0]        top;
        logic [19:0]        bot;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } track_item_t;

    // One drift result.
    typedef struct {
        logic [31:0] drift;
        logic [31:0] doca;
        logic        far;
    } drift_res_t;

    // One directed row; the result is typed in only where has_res is set.
    typedef struct {
        track_item_t item;
        bit          has_res;
        drift_res_t  res;
    } dir_row_t;

    localparam logic [127:0] SAT64 = 128'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [127:0] SAT32 = 128'hFFFF_FFFF;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [1:0]                      cfg_index = '0;
    logic [tsmd_pkg::CFG_W-1:0]      cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tsmd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tsmd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0]                      m_tuser;

    // Predictor copy of the registers.
    logic [tsmd_pkg::SEP_W-1:0]    sep_q = tsmd_pkg::DEF_SEP;
    logic [tsmd_pkg::PITCH_W-1:0]  pitch_q = tsmd_pkg::DEF_PITCH;
    logic [tsmd_pkg::RADIUS_W-1:0] radius_q = tsmd_pkg::DEF_RADIUS;

    drift_res_t pending_drifts[$];
    int         mismatches = 0;
    int         hold_seq = 0;
    bit         idle_on = 1'b1;

    track_straw_max_drift_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    // Integer square root, floor.
    function automatic logic [127:0] isqrt(input logic [127:0] v);
        logic [127:0] res;
        logic [127:0] bitv;
        res = '0;
        bitv = 128'd1 << 126;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Absolute value of a signed cross product, divided and saturated to 64 bits.
    function automatic logic [127:0] div_sat(input logic signed [127:0] n,
                                             input logic [127:0] d);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (n < 0) ? -n : n;
        q = mag / d;
        return (q > SAT64) ? SAT64 : q;
    endfunction

    // Track position in u from a crossing in pixels with 8 fractional bits.
    function automatic logic signed [127:0] crossing_pos(input logic [19:0] c);
        logic [63:0] p;
        p = (64'(c) * 64'(pitch_q) + 64'd128) >> 8;
        return $signed({64'd0, p});
    endfunction

    // Expected drift result of one item under the current registers.
    function automatic drift_res_t predict_drift(input track_item_t it);
        logic signed [127:0] px, py, cx, cy, xb, xt, s, dx, n;
        logic [127:0] len, doca, r, h, par, perp, a, hs;
        drift_res_t res;
        px = it.px;
        py = it.py;
        cx = it.cx;
        cy = it.cy;
        xt = crossing_pos(it.top);
        xb = crossing_pos(it.bot);
        s = (sep_q == 0) ? 128'sd1 : $signed({97'd0, sep_q});
        dx = xt - xb;
        len = isqrt(dx * dx + s * s);
        r = radius_q;
        n = (cx - xb) * s - cy * dx;
        doca = div_sat(n, len);
        res.doca = (doca > SAT32) ? 32'hFFFF_FFFF : doca[31:0];
        if (doca > r)
        begin
            res.drift = '0;
            res.far = 1'b1;
            return res;
        end
        h = isqrt(r * r - doca * doca);
        par = div_sat((px - cx) * dx + (py - cy) * s, len);
        perp = div_sat((px - xb) * s - py * dx, len);
        a = (par > SAT32) ? par : par + h;
        if (a > SAT32 || perp > SAT32)
            res.drift = 32'hFFFF_FFFF;
        else
        begin
            hs = a * a + perp * perp;
            if (hs > SAT64)
                res.drift = 32'hFFFF_FFFF;
            else
            begin
                hs = isqrt(hs);
                res.drift = (hs > SAT32) ? 32'hFFFF_FFFF : hs[31:0];
            end
        end
        res.far = 1'b0;
        return res;
    endfunction

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int hold_cnt;
        int seen;
        hold_cnt = 0;
        seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen)
            begin
                seen = hold_seq;
                hold_cnt = 400;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(idle_on && $urandom_range(99) < 18);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        drift_res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_drifts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result drift=%0d doca=%0d far=%0d",
                             m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
            end
            else
            begin
                e = pending_drifts.pop_front();
                if (m_tdata[31:0] !== e.drift || m_tdata[63:32] !== e.doca ||
                    m_tuser[0] !== e.far)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp drift=%0d doca=%0d far=%0d, got %0d %0d %0d",
                                 e.drift, e.doca, e.far,
                                 m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
                end
            end
        end
    end

    // Offer one item, wait for acceptance and queue its expected result.
    task automatic send_item(input track_item_t it, input bit has_res,
                             input drift_res_t res);
        s_tvalid <= 1'b1;
        s_tdata <= {it.cy, it.cx, it.py, it.px, it.bot, it.top};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_drifts.push_back(has_res ? res : predict_drift(it));
        if (idle_on && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Wait until every expected result has come, then let the pipeline drain.
    task automatic drain_results();
        while (pending_drifts.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    // Register write while the block is idle.
    task automatic write_reg(input logic [1:0] idx,
                             input logic [tsmd_pkg::CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tsmd_pkg::REG_PLANE_SEP:    sep_q = val[tsmd_pkg::SEP_W-1:0];
            tsmd_pkg::REG_PIXEL_PITCH:  pitch_q = val[tsmd_pkg::PITCH_W-1:0];
            tsmd_pkg::REG_STRAW_RADIUS: radius_q = val[tsmd_pkg::RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    // Random item: mostly a straw placed near the track, sometimes pure noise.
    function automatic track_item_t rand_item();
        track_item_t it;
        logic signed [127:0] xb, xt, sv, off;
        it.top = 20'($urandom);
        it.bot = 20'($urandom);
        it.px = 32'($urandom);
        it.py = 32'($urandom);
        it.cx = 32'($urandom);
        it.cy = 32'($urandom);
        if ($urandom_range(99) < 25)
            return it;
        it.top = 20'($urandom_range(0, 4000));
        it.bot = 20'(it.top + $urandom_range(0, 800) - 400);
        if ($urandom_range(3) == 0)
        begin
            it.top = 20'($urandom);
            it.bot = 20'(it.top ^ ($urandom & 20'h000FF));
        end
        xt = crossing_pos(it.top);
        xb = crossing_pos(it.bot);
        sv = (sep_q == 0) ? 128'sd1 : $signed({97'd0, sep_q});
        it.cy = $signed(32'($urandom_range(0, 2 * 655360))) - 32'sd327680;
        off = $signed({104'd0, radius_q}) * 3 / 2;
        off = off - $signed(128'($urandom_range(0, 32'(off) * 2)));
        it.cx = 32'(xb + (xt - xb) * $signed(128'(it.cy)) / sv + off);
        it.px = it.cx + $signed(32'($urandom_range(0, 400000))) - 32'sd200000;
        it.py = it.cy + $signed(32'($urandom_range(0, 400000))) - 32'sd200000;
        return it;
    endfunction

    // Random items for one register setting.
    task automatic run_random(input int count);
        drift_res_t none;
        none = '{default: '0};
        for (int i = 0; i < count; i++)
        begin
            idle_on = !(i >= count / 2 && i < count / 2 + 30);
            send_item(rand_item(), 1'b0, none);
        end
        idle_on = 1'b1;
    endtask

    // Main sequence.
    initial
    begin
        dir_row_t dir_rows[$];
        dir_row_t row;
        track_item_t z;
        z = '{default: '0};
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset settings.
        row = '{item: z, has_res: 1'b1, res: '{drift: 32'd163840, doca: 0, far: 0}};
        dir_rows.push_back(row);
        row.item.cx = 32'sh7FFF_FFFF;
        row.res = '{drift: 0, doca: 32'h7FFF_FFFF, far: 1};
        dir_rows.push_back(row);
        row.item.cx = 32'sh8000_0000;
        row.res = '{drift: 0, doca: 32'h8000_0000, far: 1};
        dir_rows.push_back(row);
        // Tangent track: the circle touches the track, half chord is zero.
        row.item.cx = 32'sd163840;
        row.res = '{drift: 0, doca: 32'd163840, far: 0};
        dir_rows.push_back(row);
        row.has_res = 1'b0;
        row.item = '{top: 20'hFFFFF, bot: 20'h00000, px: 32'sh7FFF_FFFF,
                     py: 32'sh8000_0000, cx: 32'sd0, cy: 32'sd0};
        dir_rows.push_back(row);
        row.item = '{top: 20'h00000, bot: 20'hFFFFF, px: 32'sh8000_0000,
                     py: 32'sh7FFF_FFFF, cx: 32'sh8000_0000, cy: 32'sh7FFF_FFFF};
        dir_rows.push_back(row);
        row.item = '{top: 20'hFFFFF, bot: 20'hFFFFF, px: -32'sd1, py: -32'sd1,
                     cx: 32'sd13000000, cy: 32'sd10};
        dir_rows.push_back(row);
        row.item = '{top: 20'd1000, bot: 20'd1200, px: 32'sd5000, py: 32'sd300000,
                     cx: 32'sd14000, cy: 32'sd327680};
        dir_rows.push_back(row);
        row.item = '{top: 20'd1000, bot: 20'd1000, px: 32'sh7FFF_FFFF, py: 32'sh7FFF_FFFF,
                     cx: 32'sd12800, cy: 32'sd0};
        dir_rows.push_back(row);
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].has_res, dir_rows[i].res);

        run_random(120);

        // Long receiver hold-off while items keep coming.
        hold_seq++;
        run_random(80);
        // Sender pause until every result has come.
        s_tvalid <= 1'b0;
        while (pending_drifts.size() != 0)
            @(posedge clk);

        // Extreme settings.
        write_reg(tsmd_pkg::REG_PLANE_SEP, 31'd1);
        write_reg(tsmd_pkg::REG_PIXEL_PITCH, 31'd65535);
        write_reg(tsmd_pkg::REG_STRAW_RADIUS, 31'hFF_FFFF);
        run_random(70);
        write_reg(tsmd_pkg::REG_PLANE_SEP, 31'h7FFF_FFFF);
        write_reg(tsmd_pkg::REG_PIXEL_PITCH, 31'd1);
        write_reg(tsmd_pkg::REG_STRAW_RADIUS, 31'd1);
        run_random(60);
        // Zero separation, zero pitch and zero radius are used as described.
        write_reg(tsmd_pkg::REG_PLANE_SEP, 31'd0);
        write_reg(tsmd_pkg::REG_PIXEL_PITCH, 31'd0);
        write_reg(tsmd_pkg::REG_STRAW_RADIUS, 31'd0);
        send_item(z, 1'b0, drift_res_t'{default: '0});
        run_random(60);
        // Out-of-range index is ignored; high data bits are dropped.
        write_reg(2'd3, 31'h1234_5678);
        write_reg(tsmd_pkg::REG_PLANE_SEP, 31'h7FFF_FFFF);
        write_reg(tsmd_pkg::REG_PIXEL_PITCH, 31'h7FFF_0CCD);
        write_reg(tsmd_pkg::REG_STRAW_RADIUS, 31'h7F02_8000);
        run_random(60);
        // A few random settings.
        repeat (5)
        begin
            write_reg(tsmd_pkg::REG_PLANE_SEP, 31'($urandom_range(1000, 2000000)));
            write_reg(tsmd_pkg::REG_PIXEL_PITCH, 31'($urandom_range(1, 65535)));
            write_reg(tsmd_pkg::REG_STRAW_RADIUS, 31'($urandom_range(1, 1000000)));
            run_random(60);
        end

        s_tvalid <= 1'b0;
        drain_results();
        if (mismatches == 0 && pending_drifts.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Run limit.
    initial
    begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/tsmd_pkg.sv
sv/tsmd_front.sv
sv/tsmd_sqrt.sv
sv/tsmd_div.sv
sv/track_straw_max_drift_unit.sv
verif/tb.sv
